### hw/rtl/edh_pkg.sv
// Package for the equal-distinct histogram: item types, codes, controller states
// and the command/status structs between controller and datapath. No dependencies.
package edh_pkg;

  localparam int ENTRY_DEPTH  = 1024;
  localparam int ENTRY_AW     = 10;
  localparam int BUCKET_DEPTH = 64;
  localparam int BUCKET_AW    = 6;
  localparam int CNT_W        = 11;
  localparam int NB_W         = 7;
  localparam int SUM_W        = 42;
  localparam int DIV_STEPS    = 11;
  localparam int DIV_CW       = 4;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_FIND = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic {
    ADDR_MID = 1'b0,
    ADDR_RES = 1'b1
  } addr_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_BUILD_INIT,
    ST_DIV,
    ST_WALK_RD,
    ST_WALK_ACC,
    ST_FINISH,
    ST_S_CHK,
    ST_S_CMP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] key;
    logic [31:0]        occurrences;
    logic               last_entry;
    logic [5:0]         bucket_sel;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [5:0]         bucket;
    logic signed [31:0] low_value;
    logic signed [31:0] high_value;
    logic [41:0]        row_total;
    logic [10:0]        distinct_in_bucket;
    logic [6:0]         bucket_total;
  } out_item_t;

  typedef struct packed {
    logic      accept;
    logic      load_store;
    logic      build_init;
    logic      div_step;
    logic      walk_acc;
    logic      set_built;
    logic      cnt_clear;
    logic      srch_init;
    logic      srch_step;
    addr_sel_t addr_sel;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic last;
    logic n_zero;
    logic div_last;
    logic walk_last;
    logic lo_lt_hi;
    logic out_busy;
  } sts_t;

endpackage

### hw/rtl/edh_ctrl.sv
// Controller state machine of the equal-distinct histogram.
// Depends on edh_pkg; drives edh_dp through cmd_t and watches sts_t.
module edh_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  edh_pkg::sts_t sts,
  output edh_pkg::cmd_t cmd
);

  edh_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= edh_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      edh_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = edh_pkg::ST_DISPATCH;
      end
      edh_pkg::ST_DISPATCH: begin
        unique case (sts.op)
          edh_pkg::OP_LOAD: state_nxt = sts.last ? edh_pkg::ST_BUILD_INIT : edh_pkg::ST_IDLE;
          edh_pkg::OP_FIND: state_nxt = edh_pkg::ST_S_CHK;
          edh_pkg::OP_READ: state_nxt = edh_pkg::ST_EMIT;
          default:          state_nxt = edh_pkg::ST_IDLE;
        endcase
      end
      edh_pkg::ST_BUILD_INIT: begin
        state_nxt = sts.n_zero ? edh_pkg::ST_IDLE : edh_pkg::ST_DIV;
      end
      edh_pkg::ST_DIV: begin
        if (sts.div_last) state_nxt = edh_pkg::ST_WALK_RD;
      end
      edh_pkg::ST_WALK_RD:  state_nxt = edh_pkg::ST_WALK_ACC;
      edh_pkg::ST_WALK_ACC: begin
        state_nxt = sts.walk_last ? edh_pkg::ST_FINISH : edh_pkg::ST_WALK_RD;
      end
      edh_pkg::ST_FINISH:   state_nxt = edh_pkg::ST_IDLE;
      edh_pkg::ST_S_CHK: begin
        state_nxt = sts.lo_lt_hi ? edh_pkg::ST_S_CMP : edh_pkg::ST_EMIT;
      end
      edh_pkg::ST_S_CMP:    state_nxt = edh_pkg::ST_S_CHK;
      edh_pkg::ST_EMIT: begin
        if (!sts.out_busy) state_nxt = edh_pkg::ST_IDLE;
      end
      default:              state_nxt = edh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.addr_sel = edh_pkg::ADDR_RES;
    in_ready     = 1'b0;
    unique case (state_r)
      edh_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      edh_pkg::ST_DISPATCH: begin
        cmd.load_store = (sts.op == edh_pkg::OP_LOAD);
        cmd.srch_init  = (sts.op == edh_pkg::OP_FIND);
      end
      edh_pkg::ST_BUILD_INIT: begin
        cmd.build_init = 1'b1;
        cmd.cnt_clear  = sts.n_zero;
      end
      edh_pkg::ST_DIV:      cmd.div_step = 1'b1;
      edh_pkg::ST_WALK_RD:  cmd.walk_acc = 1'b0;
      edh_pkg::ST_WALK_ACC: cmd.walk_acc = 1'b1;
      edh_pkg::ST_FINISH: begin
        cmd.set_built = 1'b1;
        cmd.cnt_clear = 1'b1;
      end
      edh_pkg::ST_S_CHK: begin
        cmd.addr_sel = sts.lo_lt_hi ? edh_pkg::ADDR_MID : edh_pkg::ADDR_RES;
      end
      edh_pkg::ST_S_CMP:    cmd.srch_step = 1'b1;
      edh_pkg::ST_EMIT:     cmd.out_load = !sts.out_busy;
      default:              cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst_n && (state_r == edh_pkg::ST_EMIT || state_r == edh_pkg::ST_S_CMP)) begin
      assert (sts.op == edh_pkg::OP_FIND || sts.op == edh_pkg::OP_READ)
        else $error("search or emit on a load item");
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == edh_pkg::ST_IDLE))
    else $error("ready outside idle");
  a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == edh_pkg::ST_DISPATCH))
    else $error("accepted item not dispatched");
  a_div_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == edh_pkg::ST_DIV && sts.div_last) |=> (state_r == edh_pkg::ST_WALK_RD))
    else $error("divide did not hand off to walk");

endmodule

### hw/rtl/edh_dp.sv
// Datapath of the equal-distinct histogram: entry and bucket memories, divider,
// build walk, binary search and output register. Depends on edh_pkg.
module edh_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  edh_pkg::in_item_t  in_item,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_data,
  input  edh_pkg::cmd_t      cmd,
  output edh_pkg::sts_t      sts,
  input  logic               out_ready,
  output logic               out_valid,
  output edh_pkg::out_item_t out_item
);

  logic [31:0] val_mem [edh_pkg::ENTRY_DEPTH];
  logic [31:0] occ_mem [edh_pkg::ENTRY_DEPTH];
  logic [31:0] bl_mem  [edh_pkg::BUCKET_DEPTH];
  logic [31:0] bh_mem  [edh_pkg::BUCKET_DEPTH];
  logic [edh_pkg::SUM_W-1:0] bs_mem [edh_pkg::BUCKET_DEPTH];

  logic [31:0] val_rd_r, occ_rd_r, bl_rd_r, bh_rd_r;
  logic [edh_pkg::SUM_W-1:0] bs_rd_r;

  edh_pkg::in_item_t  item_r;
  edh_pkg::out_item_t out_item_r, out_item_nxt;
  logic                       out_valid_r;
  logic [6:0]                 mb_r;
  logic [edh_pkg::CNT_W-1:0]  cnt_r, share_r, div_n_r, pos_r;
  logic [5:0]                 extra_r, b_r;
  logic [edh_pkg::NB_W-1:0]   built_r, nb_r, div_rem_r, lo_r, hi_r;
  logic [edh_pkg::DIV_CW-1:0] div_cnt_r;
  logic [edh_pkg::ENTRY_AW-1:0] walk_i_r;
  logic [31:0]                low_r;
  logic [edh_pkg::SUM_W-1:0]  sum_r;

  logic [6:0]                 lim, nb_nxt;
  logic [7:0]                 trial, trial_sub;
  logic                       trial_ge;
  logic [edh_pkg::NB_W-1:0]   rem_nxt;
  logic [7:0]                 mid_sum;
  logic [edh_pkg::NB_W-1:0]   mid;
  logic [edh_pkg::CNT_W-1:0]  len, cnt_m1;
  logic                       seg_end;
  logic [31:0]                low_cur;
  logic [edh_pkg::SUM_W-1:0]  sum_cur;
  logic [5:0]                 rd_addr, res_idx;
  logic                       hit;

  always_comb begin
    if (mb_r == 7'd0) lim = 7'd1;
    else if (mb_r > 7'(edh_pkg::BUCKET_DEPTH)) lim = 7'(edh_pkg::BUCKET_DEPTH);
    else lim = mb_r;
    nb_nxt    = (cnt_r < {4'd0, lim}) ? cnt_r[6:0] : lim;
    trial     = {div_rem_r, div_n_r[edh_pkg::CNT_W-1]};
    trial_ge  = (trial >= {1'b0, nb_r});
    trial_sub = trial - {1'b0, nb_r};
    rem_nxt   = trial_ge ? trial_sub[6:0] : trial[6:0];
    mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
    mid       = mid_sum[7:1];
    len       = share_r + {10'd0, (b_r < extra_r)};
    cnt_m1    = cnt_r - 11'd1;
    seg_end   = (pos_r == len - 11'd1);
    low_cur   = (pos_r == '0) ? val_rd_r : low_r;
    sum_cur   = ((pos_r == '0) ? '0 : sum_r) + {10'd0, occ_rd_r};
    res_idx   = (item_r.operation == edh_pkg::OP_FIND) ? lo_r[5:0] : item_r.bucket_sel;
    rd_addr   = (cmd.addr_sel == edh_pkg::ADDR_MID) ? mid[5:0] : res_idx;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_store && (cnt_r != 11'(edh_pkg::ENTRY_DEPTH))) begin
      val_mem[cnt_r[edh_pkg::ENTRY_AW-1:0]] <= item_r.key;
      occ_mem[cnt_r[edh_pkg::ENTRY_AW-1:0]] <= item_r.occurrences;
    end
    val_rd_r <= val_mem[walk_i_r];
    occ_rd_r <= occ_mem[walk_i_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_acc && seg_end) begin
      bl_mem[b_r] <= low_cur;
      bh_mem[b_r] <= val_rd_r;
      bs_mem[b_r] <= sum_cur;
    end
    bl_rd_r <= bl_mem[rd_addr];
    bh_rd_r <= bh_mem[rd_addr];
    bs_rd_r <= bs_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mb_r        <= 7'd64;
      cnt_r       <= '0;
      share_r     <= '0;
      extra_r     <= '0;
      built_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) mb_r <= cfg_data;
      if (cmd.load_store && (cnt_r != 11'(edh_pkg::ENTRY_DEPTH))) cnt_r <= cnt_r + 11'd1;
      if (cmd.cnt_clear) cnt_r <= '0;
      if (cmd.div_step) begin
        share_r <= {share_r[edh_pkg::CNT_W-2:0], trial_ge};
        if (div_cnt_r == 4'(edh_pkg::DIV_STEPS - 1)) extra_r <= rem_nxt[5:0];
      end
      if (cmd.set_built) built_r <= nb_r;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) item_r <= in_item;
    if (cmd.build_init) begin
      nb_r      <= nb_nxt;
      div_n_r   <= cnt_r;
      div_rem_r <= '0;
      div_cnt_r <= '0;
      walk_i_r  <= '0;
      pos_r     <= '0;
      b_r       <= '0;
    end
    if (cmd.div_step) begin
      div_n_r   <= {div_n_r[edh_pkg::CNT_W-2:0], 1'b0};
      div_rem_r <= rem_nxt;
      div_cnt_r <= div_cnt_r + 4'd1;
    end
    if (cmd.walk_acc) begin
      walk_i_r <= walk_i_r + 10'd1;
      low_r    <= low_cur;
      sum_r    <= sum_cur;
      if (seg_end) begin
        pos_r <= '0;
        b_r   <= b_r + 6'd1;
      end else begin
        pos_r <= pos_r + 11'd1;
      end
    end
    if (cmd.srch_init) begin
      lo_r <= '0;
      hi_r <= built_r;
    end
    if (cmd.srch_step) begin
      if ($signed(bh_rd_r) < item_r.key) lo_r <= mid + 7'd1;
      else hi_r <= mid;
    end
    if (cmd.out_load) out_item_r <= out_item_nxt;
  end

  always_comb begin
    if (item_r.operation == edh_pkg::OP_FIND) begin
      hit = (lo_r < built_r) && (item_r.key >= $signed(bl_rd_r)) &&
            (item_r.key <= $signed(bh_rd_r));
    end else begin
      hit = ({1'b0, item_r.bucket_sel} < built_r);
    end
    out_item_nxt              = '0;
    out_item_nxt.bucket_total = built_r;
    out_item_nxt.found        = hit;
    if (item_r.operation == edh_pkg::OP_READ) out_item_nxt.bucket = item_r.bucket_sel;
    if (hit) begin
      out_item_nxt.bucket             = res_idx;
      out_item_nxt.low_value          = bl_rd_r;
      out_item_nxt.high_value         = bh_rd_r;
      out_item_nxt.row_total          = bs_rd_r;
      out_item_nxt.distinct_in_bucket = share_r + {10'd0, (res_idx < extra_r)};
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    sts           = '0;
    sts.op        = edh_pkg::op_t'(item_r.operation);
    sts.last      = item_r.last_entry;
    sts.n_zero    = (cnt_r == '0);
    sts.div_last  = (div_cnt_r == 4'(edh_pkg::DIV_STEPS - 1));
    sts.walk_last = (walk_i_r == cnt_m1[edh_pkg::ENTRY_AW-1:0]);
    sts.lo_lt_hi  = (lo_r < hi_r);
    sts.out_busy  = out_valid_r && !out_ready;
  end

  a_built_max: assert property (@(posedge clk) disable iff (!rst_n)
    built_r <= 7'(edh_pkg::BUCKET_DEPTH))
    else $error("bucket count above capacity");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 11'(edh_pkg::ENTRY_DEPTH))
    else $error("entry count above capacity");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

endmodule

### hw/rtl/equal_distinct_histogram_core.sv
// Equal-distinct-count histogram: up to 1024 entries load one per item, the last
// entry builds up to 64 buckets. A build runs an 11-step divider, then walks the
// entries with a read state and an accumulate state per entry over the
// registered entry memory. A lookup does a binary search on the registered
// bucket-maximum memory; a read by index goes straight to the bucket. One item
// is processed at a time; a finished result sits in the output register while
// the next item is taken.
module equal_distinct_histogram_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  edh_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output edh_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_data
);

  edh_pkg::cmd_t cmd;
  edh_pkg::sts_t sts;

  edh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  edh_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
